// ===== rtl/ssa_pkg.sv =====
// Package with shared types and constants of the seek steering agent.
package ssa_pkg;

	localparam int unsigned CW = 32;

	// Requests from the sequencer to the resize unit.
	typedef struct packed {
		logic        start;
		logic        only_longer;
		logic [31:0] want;
	} rsz_req_t;

	// Status returned by the resize unit.
	typedef struct packed {
		logic busy;
		logic done;
	} rsz_sts_t;

	// Saturate a signed 64-bit value to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_0000_7FFF_FFFF;
		lo = -64'sh0000_0000_8000_0000;
		if (v > hi) return 32'sh7FFF_FFFF;
		if (v < lo) return 32'sh8000_0000;
		return v[31:0];
	endfunction

endpackage

// ===== rtl/seek_steering_agent_step.sv =====
// Top level of the seek steering agent: sequencer, state, trail and output register.
//
// Usage: one input beat on s_axis (op in tuser, targets and bounce in tdata)
// produces exactly one output beat on m_axis with position, velocity and the
// oldest trail point. Configuration is written through cfg_we/cfg_index/
// cfg_data while the block is idle.
// A resize pass finds the vector length by a square root, two radicand bits a
// cycle, and then, when it divides, sends each of the three components
// through a restoring divider at one quotient bit a cycle.
// A seek item uses the resize unit twice, a step item once. s_axis_tready
// stays low while an item is at work and while its result waits in the output
// register; the next beat is taken the cycle after the result is taken.
// When the receiver stalls, the result holds in that register until taken.
// Reset clears position, velocity, acceleration and the trail count; the
// trail memory has no clearing pass and its unwritten entries are never read.
module seek_steering_agent_step #(
	parameter int TRAIL_LEN = 50
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: target_x, target_y, target_z, bounce_x, bounce_y, bounce_z
	input  logic [191:0] s_axis_tdata,
	// tuser: op
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: pos_x/y/z, vel_x/y/z, oldest_x/y/z
	output logic [287:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [20:0]  cfg_data
);
	import ssa_pkg::*;

	localparam int AW = (TRAIL_LEN > 1) ? $clog2(TRAIL_LEN) : 1;

	localparam logic [2:0] REG_SPEED = 3'd0;
	localparam logic [2:0] REG_FORCE = 3'd1;
	localparam logic [2:0] REG_BNC   = 3'd2;
	localparam logic [2:0] REG_GEN   = 3'd3;
	localparam logic [2:0] REG_GX    = 3'd4;
	localparam logic [2:0] REG_GY    = 3'd5;
	localparam logic [2:0] REG_GZ    = 3'd6;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_SEEK1 = 8'b00000010,
		S_SEEK2 = 8'b00000100,
		S_SEEK3 = 8'b00001000,
		S_STEP1 = 8'b00010000,
		S_STEP2 = 8'b00100000,
		S_READ  = 8'b01000000,
		S_OUT   = 8'b10000000
	} state_t;

	state_t              state_q;
	logic                wait_q;
	logic [20:0]         speed_q;
	logic [18:0]         force_q;
	logic                bnc_q, gen_q;
	logic signed [19:0]  grav_q [3];
	logic signed [31:0]  pos_q [3], vel_q [3], acc_q [3];
	logic signed [31:0]  tgt_q [3], bnc_v_q [3];
	logic [AW-1:0]       head_q;
	logic [AW:0]         fill_q;
	logic [AW-1:0]       raddr;
	logic [95:0]         trail_rd;
	logic [287:0]        out_q;
	logic signed [63:0]  vin [3], vout [3];
	rsz_req_t            req;
	rsz_sts_t            sts;
	logic [AW:0]         kk;

	ssa_resize u_rsz (
		.clk(clk), .arst_n(arst_n), .req(req), .vin(vin), .vout(vout), .sts(sts)
	);

	ssa_ram #(.WIDTH(96), .DEPTH(TRAIL_LEN)) u_trail (
		.clk(clk), .we(state_q == S_STEP2 && sts.done), .waddr(head_q),
		.wdata({sat32(64'(pos_q[2]) + 64'(sat32(vout[2]))),
		        sat32(64'(pos_q[1]) + 64'(sat32(vout[1]))),
		        sat32(64'(pos_q[0]) + 64'(sat32(vout[0])))}),
		.raddr(raddr), .rdata(trail_rd)
	);

	// Oldest entry index: head minus fill, modulo the trail length.
	assign kk = ({1'b0, head_q} >= fill_q) ? ({1'b0, head_q} - fill_q)
	                                       : ({1'b0, head_q} + (AW+1)'(TRAIL_LEN) - fill_q);
	assign raddr = kk[AW-1:0];

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata  = out_q;

	// Resize unit operands per phase.
	always_comb begin
		req = '0;
		for (int i = 0; i < 3; i++) vin[i] = '0;
		unique case (state_q)
			S_SEEK1: begin
				req.start = !wait_q;
				req.want  = {11'd0, speed_q};
				for (int i = 0; i < 3; i++) vin[i] = 64'(tgt_q[i]) - 64'(pos_q[i]);
			end
			S_SEEK2: begin
				req.start = !wait_q;
				req.only_longer = 1'b1;
				req.want  = {13'd0, force_q};
				for (int i = 0; i < 3; i++) vin[i] = vout[i] - 64'(vel_q[i]);
			end
			S_STEP1: begin
				req.start = 1'b1;
				req.only_longer = 1'b1;
				req.want  = {11'd0, speed_q};
				for (int i = 0; i < 3; i++)
					vin[i] = 64'(vel_q[i]) + (bnc_q ? 64'(bnc_v_q[i]) : 64'sd0)
					       + (gen_q ? 64'(grav_q[i]) : 64'sd0) + 64'(acc_q[i]);
			end
			default: ;
		endcase
	end

	// Main sequencer and agent state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wait_q  <= 1'b0;
			speed_q <= 21'd655360;
			force_q <= 19'd229376;
			bnc_q   <= 1'b0;
			gen_q   <= 1'b0;
			grav_q[0] <= '0;
			grav_q[1] <= '0;
			grav_q[2] <= -20'sd65536;
			head_q  <= '0;
			fill_q  <= '0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				acc_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SPEED: speed_q   <= cfg_data;
					REG_FORCE: force_q   <= cfg_data[18:0];
					REG_BNC:   bnc_q     <= cfg_data[0];
					REG_GEN:   gen_q     <= cfg_data[0];
					REG_GX:    grav_q[0] <= cfg_data[19:0];
					REG_GY:    grav_q[1] <= cfg_data[19:0];
					REG_GZ:    grav_q[2] <= cfg_data[19:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						for (int i = 0; i < 3; i++) begin
							tgt_q[i]   <= s_axis_tdata[32*i +: 32];
							bnc_v_q[i] <= s_axis_tdata[96 + 32*i +: 32];
						end
						wait_q  <= 1'b0;
						state_q <= s_axis_tuser ? S_STEP1 : S_SEEK1;
					end
				end
				S_SEEK1: begin
					wait_q <= !sts.done;
					if (sts.done) state_q <= S_SEEK2;
				end
				S_SEEK2: begin
					wait_q <= 1'b1;
					if (sts.done) state_q <= S_SEEK3;
				end
				S_SEEK3: begin
					for (int i = 0; i < 3; i++)
						acc_q[i] <= sat32(64'(acc_q[i]) + vout[i]);
					state_q <= S_READ;
				end
				S_STEP1: state_q <= S_STEP2;
				S_STEP2: begin
					if (sts.done) begin
						for (int i = 0; i < 3; i++) begin
							vel_q[i] <= sat32(vout[i]);
							pos_q[i] <= sat32(64'(pos_q[i]) + 64'(sat32(vout[i])));
							acc_q[i] <= '0;
						end
						head_q <= (head_q == AW'(TRAIL_LEN - 1)) ? '0 : head_q + AW'(1);
						if (fill_q != (AW+1)'(TRAIL_LEN)) fill_q <= fill_q + (AW+1)'(1);
						state_q <= S_READ;
					end
				end
				S_READ: begin
					// After a step, wait for the registered read of the new oldest entry.
					wait_q <= ~wait_q;
					if (wait_q) begin
						out_q[95:0]    <= {pos_q[2], pos_q[1], pos_q[0]};
						out_q[191:96]  <= {vel_q[2], vel_q[1], vel_q[0]};
						out_q[287:192] <= (fill_q == '0) ? {pos_q[2], pos_q[1], pos_q[0]}
						                                 : trail_rd;
						state_q <= S_OUT;
					end
				end
				S_OUT: if (m_axis_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (AW+1)'(TRAIL_LEN)) else $error("trail fill overflow");
	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, head_q} < (AW+1)'(TRAIL_LEN)) else $error("trail head out of range");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(out_q))
		else $error("result changed while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sts.busy |-> !s_axis_tready) else $error("ready while resize busy");
`endif
endmodule

// ===== rtl/ssa_ram.sv =====
// Generic single-port-write RAM with a registered read.
module ssa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/ssa_resize.sv =====
// Iterative resize unit: length by square root, then three divisions or none.
module ssa_resize (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ssa_pkg::rsz_req_t      req,
	input  logic signed [63:0]     vin [3],
	output logic signed [63:0]     vout [3],
	output ssa_pkg::rsz_sts_t      sts
);
	import ssa_pkg::*;

	typedef enum logic [6:0] {
		R_IDLE = 7'b0000001,
		R_MAG  = 7'b0000010,
		R_SHFT = 7'b0000100,
		R_SQ   = 7'b0001000,
		R_SQRT = 7'b0010000,
		R_CHK  = 7'b0100000,
		R_DIV  = 7'b1000000
	} rstate_t;

	rstate_t            state_q;
	logic [63:0]        m_q [3];
	logic [2:0]         neg_q;
	logic [5:0]         sh_q;
	logic [1:0]         idx_q;
	logic [63:0]        sum_q;
	logic [63:0]        rem_q;
	logic [63:0]        root_q;
	logic [63:0]        bit_q;
	logic [5:0]         cnt_q;
	logic [63:0]        dvd_q;
	logic [63:0]        quo_q;
	logic [63:0]        drem_q;
	logic               ol_q;
	logic [31:0]        want_q;
	logic               done_q;
	logic [63:0]        mx;
	logic [1:0]         msel;
	logic [63:0]        prod;
	logic [64:0]        trial;
	logic [64:0]        dtrial;
	logic [63:0]        lenw;

	assign mx = (m_q[0] > m_q[1]) ? ((m_q[0] > m_q[2]) ? m_q[0] : m_q[2])
	                              : ((m_q[1] > m_q[2]) ? m_q[1] : m_q[2]);
	// While dividing, the multiplier prepares the dividend of the next component.
	assign msel = (state_q == R_DIV && idx_q != 2'd2) ? idx_q + 2'd1 : idx_q;
	// One shared 32x32 multiplier: squares, then component times wanted length.
	assign prod = (state_q == R_SQ) ? {32'd0, m_q[msel][31:0]} * {32'd0, m_q[msel][31:0]}
	                                : {32'd0, m_q[msel][31:0]} * {32'd0, want_q};
	assign trial = {1'b0, rem_q} - ({1'b0, root_q} + {1'b0, bit_q});
	assign dtrial = {drem_q, dvd_q[63]} - {1'b0, root_q};
	assign lenw = root_q << sh_q;
	assign sts.busy = (state_q != R_IDLE);
	assign sts.done = done_q;

	// Sequencer over magnitude, normalize shift, square sum, root and divide.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				R_IDLE: begin
					if (req.start) begin
						for (int i = 0; i < 3; i++) begin
							vout[i] <= vin[i];
							neg_q[i] <= vin[i][63];
						end
						ol_q    <= req.only_longer;
						want_q  <= req.want;
						state_q <= R_MAG;
					end
				end
				R_MAG: begin
					for (int i = 0; i < 3; i++)
						m_q[i] <= neg_q[i] ? (64'd0 - vout[i]) : vout[i];
					sh_q    <= '0;
					state_q <= R_SHFT;
				end
				R_SHFT: begin
					if (mx[63:31] != '0) begin
						for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
						sh_q <= sh_q + 6'd1;
					end else begin
						idx_q   <= 2'd0;
						sum_q   <= '0;
						state_q <= R_SQ;
					end
				end
				R_SQ: begin
					sum_q <= sum_q + prod;
					if (idx_q == 2'd2) begin
						rem_q   <= sum_q + prod;
						root_q  <= '0;
						bit_q   <= 64'd1 << 62;
						idx_q   <= 2'd0;
						state_q <= R_SQRT;
					end else idx_q <= idx_q + 2'd1;
				end
				R_SQRT: begin
					if (bit_q == '0) state_q <= R_CHK;
					else if (bit_q > rem_q && root_q == '0) bit_q <= bit_q >> 2;
					else begin
						if (!trial[64]) begin
							rem_q  <= trial[63:0];
							root_q <= (root_q >> 1) + bit_q;
						end else root_q <= root_q >> 1;
						bit_q <= bit_q >> 2;
					end
				end
				R_CHK: begin
					if (root_q == '0 || (ol_q && (lenw >> sh_q) == root_q
					    && lenw <= {32'd0, want_q})) begin
						done_q  <= 1'b1;
						state_q <= R_IDLE;
					end else begin
						idx_q   <= 2'd0;
						cnt_q   <= '0;
						dvd_q   <= prod;
						drem_q  <= '0;
						state_q <= R_DIV;
					end
				end
				R_DIV: begin
					// Restoring division, one quotient bit a cycle.
					if (!dtrial[64]) begin
						drem_q <= dtrial[63:0];
						quo_q  <= {quo_q[62:0], 1'b1};
					end else begin
						drem_q <= {drem_q[62:0], dvd_q[63]};
						quo_q  <= {quo_q[62:0], 1'b0};
					end
					dvd_q <= dvd_q << 1;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						vout[idx_q] <= neg_q[idx_q]
							? 64'd0 - (dtrial[64] ? {quo_q[62:0], 1'b0} : {quo_q[62:0], 1'b1})
							: (dtrial[64] ? {quo_q[62:0], 1'b0} : {quo_q[62:0], 1'b1});
						if (idx_q == 2'd2) begin
							done_q  <= 1'b1;
							state_q <= R_IDLE;
						end else begin
							idx_q  <= idx_q + 2'd1;
							dvd_q  <= prod;
							drem_q <= '0;
						end
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == R_IDLE) else $error("done outside idle");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == R_IDLE && req.start) |=> state_q == R_MAG) else $error("start lost");
	a_shift_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == R_SQ |-> mx[63:31] == '0) else $error("shift incomplete");
`endif
endmodule
